// ===== rtl/grid_line_of_sight_check_assert.svh =====
// Assertion helpers shared by the line-of-sight checker.
// Both sample on clock and are disabled while reset is high.
`ifndef GRID_LINE_OF_SIGHT_CHECK_ASSERT_SVH
`define GRID_LINE_OF_SIGHT_CHECK_ASSERT_SVH

// Same-cycle implication
`define GLOSC_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define GLOSC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/glosc_pkg.sv =====
`default_nettype none

package glosc_pkg;

   // Coordinate field width and default grid size
   localparam int COORD_W    = 6;
   localparam int GRID_W_DEF = 64;
   localparam int GRID_H_DEF = 64;

   // Bresenham error term width: |err| stays well below 2^(ERR_W-1)
   localparam int ERR_W = COORD_W + 3;

   // Command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Line to walk, loaded into the stepper
   typedef struct packed {
      logic [COORD_W-1:0] x0;
      logic [COORD_W-1:0] z0;
      logic [COORD_W-1:0] x1;
      logic [COORD_W-1:0] z1;
   } step_cmd_type;

   // Current stepper position
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] z;
      logic               at_end;
   } step_stat_type;

endpackage

`default_nettype wire

// ===== rtl/glosc_map.sv =====
`default_nettype none

module glosc_map #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic          rd_data,
   output logic          busy
);

   logic          map_ff [DEPTH];
   logic          rd_data_ff;
   logic          busy_ff;
   logic          busy_in;
   logic [AW-1:0] clear_cnt_ff;
   logic [AW-1:0] clear_cnt_in;
   logic          mem_we;
   logic [AW-1:0] mem_addr;
   logic          mem_d;

   // Clearing pass after reset, one entry per cycle
   always_comb begin
      busy_in      = busy_ff;
      clear_cnt_in = clear_cnt_ff;
      if (busy_ff) begin
         clear_cnt_in = clear_cnt_ff + AW'(1);
         if (clear_cnt_ff == AW'(DEPTH - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         clear_cnt_ff <= '0;
      end else begin
         busy_ff      <= busy_in;
         clear_cnt_ff <= clear_cnt_in;
      end
   end

   // Write port: clearing pass has priority
   assign mem_we   = busy_ff | wr_en;
   assign mem_addr = busy_ff ? clear_cnt_ff : wr_addr;
   assign mem_d    = busy_ff ? 1'b0 : wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_ff[mem_addr] <= mem_d;
      end
      rd_data_ff <= map_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

`default_nettype wire

// ===== rtl/glosc_step.sv =====
`default_nettype none

module glosc_step (
   input  logic                     clock,
   input  logic                     load,
   input  glosc_pkg::step_cmd_type  cmd,
   input  logic                     advance,
   output glosc_pkg::step_stat_type stat
);

   localparam int CW   = glosc_pkg::COORD_W;
   localparam int EW   = glosc_pkg::ERR_W;
   localparam int E2W  = EW + 1;

   logic [CW-1:0]         x_ff, x_in;
   logic [CW-1:0]         z_ff, z_in;
   logic [CW-1:0]         x1_ff, x1_in;
   logic [CW-1:0]         z1_ff, z1_in;
   logic [CW-1:0]         dx_ff, dx_in;
   logic [CW-1:0]         dz_ff, dz_in;
   logic                  x_dec_ff, x_dec_in;
   logic                  z_dec_ff, z_dec_in;
   logic signed [EW-1:0]  err_ff, err_in;

   logic [CW-1:0]         dx_ld;
   logic [CW-1:0]         dz_ld;
   logic signed [EW-1:0]  dx_e;
   logic signed [EW-1:0]  dz_e;
   logic signed [E2W-1:0] e2;
   logic signed [E2W-1:0] dx_e2;
   logic signed [E2W-1:0] dz_e2;
   logic                  step_x;
   logic                  step_z;

   // Line setup
   assign dx_ld = (cmd.x1 > cmd.x0) ? cmd.x1 - cmd.x0 : cmd.x0 - cmd.x1;
   assign dz_ld = (cmd.z1 > cmd.z0) ? cmd.z1 - cmd.z0 : cmd.z0 - cmd.z1;

   // Shared step unit: error compare and update
   assign dx_e   = $signed({{(EW - CW){1'b0}}, dx_ff});
   assign dz_e   = $signed({{(EW - CW){1'b0}}, dz_ff});
   assign e2     = $signed({err_ff, 1'b0});
   assign dx_e2  = $signed({{(E2W - CW){1'b0}}, dx_ff});
   assign dz_e2  = $signed({{(E2W - CW){1'b0}}, dz_ff});
   assign step_x = e2 > -dz_e2;
   assign step_z = e2 < dx_e2;

   always_comb begin
      x_in     = x_ff;
      z_in     = z_ff;
      x1_in    = x1_ff;
      z1_in    = z1_ff;
      dx_in    = dx_ff;
      dz_in    = dz_ff;
      x_dec_in = x_dec_ff;
      z_dec_in = z_dec_ff;
      err_in   = err_ff;
      if (load) begin
         x_in     = cmd.x0;
         z_in     = cmd.z0;
         x1_in    = cmd.x1;
         z1_in    = cmd.z1;
         dx_in    = dx_ld;
         dz_in    = dz_ld;
         x_dec_in = !(cmd.x0 < cmd.x1);
         z_dec_in = !(cmd.z0 < cmd.z1);
         err_in   = $signed({{(EW - CW){1'b0}}, dx_ld}) - $signed({{(EW - CW){1'b0}}, dz_ld});
      end else if (advance) begin
         err_in = err_ff - (step_x ? dz_e : EW'(0)) + (step_z ? dx_e : EW'(0));
         if (step_x) begin
            x_in = x_dec_ff ? x_ff - CW'(1) : x_ff + CW'(1);
         end
         if (step_z) begin
            z_in = z_dec_ff ? z_ff - CW'(1) : z_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      z_ff     <= z_in;
      x1_ff    <= x1_in;
      z1_ff    <= z1_in;
      dx_ff    <= dx_in;
      dz_ff    <= dz_in;
      x_dec_ff <= x_dec_in;
      z_dec_ff <= z_dec_in;
      err_ff   <= err_in;
   end

   assign stat.x      = x_ff;
   assign stat.z      = z_ff;
   assign stat.at_end = (x_ff == x1_ff) && (z_ff == z1_ff);

endmodule

`default_nettype wire

// ===== rtl/grid_line_of_sight_check.sv =====
// Grid line-of-sight checker.
// Request channel (req_*): cmd 0 writes the walkable bit of cell (start_x, start_z);
// cmd 1 queries the Bresenham line from (start_x, start_z) to (end_x, end_z).
// Response channel (rsp_*): one transfer per query carrying line_clear, none per write.
// Cells outside the GRID_W x GRID_H grid read as blocked; writes to them are dropped.
// Query: a query walks one cell per cycle through the stepper and the registered map
// read port, over a line of max(|dx|, |dz|) + 1 cells (at most 64); the walk stops
// early at the first blocked cell. req_ready is low during the walk and stays low
// until the answer has gone to the output register.
// Reset: the map is swept to all blocked, one cell per cycle, covering
// min(GRID_W,64) * min(GRID_H,64) cells (4096 by default); req_ready stays low
// meanwhile and rises in the cycle after the sweep ends.
// Stalls: the response sits in an output register; writes and a new query are taken
// while it waits. A finished query whose slot is still full waits until rsp_ready.
`default_nettype none
`include "grid_line_of_sight_check_assert.svh"

module grid_line_of_sight_check #(
   parameter int GRID_W = glosc_pkg::GRID_W_DEF,
   parameter int GRID_H = glosc_pkg::GRID_H_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_cmd,
   input  logic [glosc_pkg::COORD_W-1:0] req_start_x,
   input  logic [glosc_pkg::COORD_W-1:0] req_start_z,
   input  logic [glosc_pkg::COORD_W-1:0] req_end_x,
   input  logic [glosc_pkg::COORD_W-1:0] req_end_z,
   input  logic                          req_cell_walkable,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_line_clear
);

   // Only coordinates reachable by the fields need storage
   localparam int COORD_SPAN = 1 << glosc_pkg::COORD_W;
   localparam int MAP_W      = (GRID_W < COORD_SPAN) ? GRID_W : COORD_SPAN;
   localparam int MAP_H      = (GRID_H < COORD_SPAN) ? GRID_H : COORD_SPAN;
   localparam int DEPTH      = MAP_W * MAP_H;
   localparam int AW         = $clog2(DEPTH);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_WALK  = 5'b00100,
      ST_LAST  = 5'b01000,
      ST_HOLD  = 5'b10000
   } state_type;

   state_type                state_ff, state_in;
   logic                     pend_valid_ff, pend_valid_in;
   logic                     pend_oob_ff, pend_oob_in;
   logic                     result_ff, result_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_line_clear_ff, rsp_line_clear_in;

   logic                     req_xfer;
   logic                     slot_free;
   logic                     cell_ok;
   logic                     wr_in_grid;
   logic                     cur_in_grid;
   logic                     map_wr_en;
   logic [AW-1:0]            map_wr_addr;
   logic [AW-1:0]            map_rd_addr;
   logic                     map_rd_data;
   logic                     map_busy;
   logic                     step_load;
   logic                     step_adv;
   logic                     resolved;
   logic                     res_val;
   glosc_pkg::step_cmd_type  step_cmd;
   glosc_pkg::step_stat_type step_stat;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Cell write path
   assign wr_in_grid  = (int'(req_start_x) < MAP_W) && (int'(req_start_z) < MAP_H);
   assign map_wr_en   = req_xfer && (req_cmd == glosc_pkg::CMD_WRITE) && wr_in_grid;
   assign map_wr_addr = wr_in_grid ? AW'(int'(req_start_z) * MAP_W + int'(req_start_x))
                                   : '0;

   // Read address of the cell under the stepper
   assign cur_in_grid = (int'(step_stat.x) < MAP_W) && (int'(step_stat.z) < MAP_H);
   assign map_rd_addr = cur_in_grid ? AW'(int'(step_stat.z) * MAP_W + int'(step_stat.x))
                                    : '0;

   glosc_map #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_map (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (req_cell_walkable),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data),
      .busy    (map_busy)
   );

   assign step_cmd.x0 = req_start_x;
   assign step_cmd.z0 = req_start_z;
   assign step_cmd.x1 = req_end_x;
   assign step_cmd.z1 = req_end_z;
   assign step_load   = req_xfer && (req_cmd == glosc_pkg::CMD_QUERY);

   glosc_step u_step (
      .clock   (clock),
      .load    (step_load),
      .cmd     (step_cmd),
      .advance (step_adv),
      .stat    (step_stat)
   );

   // Map data of the cell issued in the previous cycle
   assign cell_ok = !pend_oob_ff && map_rd_data;

   // Sequencer
   always_comb begin
      state_in          = state_ff;
      pend_valid_in     = 1'b0;
      pend_oob_in       = !cur_in_grid;
      result_in         = result_ff;
      step_adv          = 1'b0;
      resolved          = 1'b0;
      res_val           = 1'b0;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_line_clear_in = rsp_line_clear_ff;

      case (state_ff)
         ST_CLEAR: begin
            if (!map_busy) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (step_load) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (pend_valid_ff && !cell_ok) begin
               // blocked cell seen: stop early
               resolved = 1'b1;
               res_val  = 1'b0;
            end else begin
               pend_valid_in = 1'b1;
               if (step_stat.at_end) begin
                  state_in = ST_LAST;
               end else begin
                  step_adv = 1'b1;
               end
            end
         end
         ST_LAST: begin
            resolved = 1'b1;
            res_val  = cell_ok;
         end
         ST_HOLD: begin
            if (slot_free) begin
               rsp_valid_in      = 1'b1;
               rsp_line_clear_in = result_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Hand the answer to the output register, or park it
      if (resolved) begin
         if (slot_free) begin
            rsp_valid_in      = 1'b1;
            rsp_line_clear_in = res_val;
            state_in          = ST_IDLE;
         end else begin
            result_in = res_val;
            state_in  = ST_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_oob_ff       <= pend_oob_in;
      result_ff         <= result_in;
      rsp_line_clear_ff <= rsp_line_clear_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_line_clear = rsp_line_clear_ff;

   // Checks
   `GLOSC_ASSERT_IMPL(a_no_req_during_clear, map_busy, !req_ready, "request taken during map clear")
   `GLOSC_ASSERT_NEXT(a_query_starts_walk, step_load, state_ff == ST_WALK, "query did not start walk")
   `GLOSC_ASSERT_IMPL(a_hold_slot_full, state_ff == ST_HOLD, rsp_valid_ff, "parked answer, free slot")
   `GLOSC_ASSERT_IMPL(a_last_has_pending, state_ff == ST_LAST, pend_valid_ff, "end cell not issued")

endmodule

`default_nettype wire

// ===== dv/glosc_line_checker.sv =====
// Watches both channels of the line-of-sight checker, keeps its own copy of
// the walkable map and predicts line_clear for every accepted query.
module glosc_line_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          req_cmd,
   input  logic [glosc_pkg::COORD_W-1:0] req_start_x,
   input  logic [glosc_pkg::COORD_W-1:0] req_start_z,
   input  logic [glosc_pkg::COORD_W-1:0] req_end_x,
   input  logic [glosc_pkg::COORD_W-1:0] req_end_z,
   input  logic                          req_cell_walkable,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic                          rsp_line_clear,
   output int                            fail_count,
   output int                            outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAP_W      = glosc_pkg::GRID_W_DEF;
   localparam int MAP_H      = glosc_pkg::GRID_H_DEF;
   localparam int SHOW_LIMIT = 10;

   // One pending query with the answer it should get
   typedef struct {
      bit clear;
      int x0;
      int z0;
      int x1;
      int z1;
   } sight_line_type;

   bit             walkable_cells [MAP_H][MAP_W];
   sight_line_type clear_expected [$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   // Cells off the grid count as blocked
   function automatic bit cell_open(int x, int z);
      if (x < 0 || z < 0 || x >= MAP_W || z >= MAP_H)
         return 1'b0;
      return walkable_cells[z][x];
   endfunction

   // Step the Bresenham line, endpoints included, stop at first blocked cell
   function automatic bit walk_is_clear(int x0, int z0, int x1, int z1);
      int dx, dz, sx, sz, err, e2, x, z;
      dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
      dz  = (z1 > z0) ? z1 - z0 : z0 - z1;
      sx  = (x0 < x1) ? 1 : -1;
      sz  = (z0 < z1) ? 1 : -1;
      err = dx - dz;
      x   = x0;
      z   = z0;
      for (int n = 0; n < dx + dz + 1; n++) begin
         if (!cell_open(x, z))
            return 1'b0;
         if (x == x1 && z == z1)
            return 1'b1;
         e2 = 2 * err;
         if (e2 > -dz) begin
            err -= dz;
            x   += sx;
         end
         if (e2 < dx) begin
            err += dx;
            z   += sz;
         end
      end
      return 1'b1;
   endfunction

   task automatic note_failure(string msg);
      fail_count++;
      if (fail_count <= SHOW_LIMIT)
         $display("%0t: %s", $realtime, msg);
   endtask

   // Response check first, then the request: a response never belongs to
   // a query taken at the same edge
   always @(posedge clock) begin : track
      sight_line_type want;
      sight_line_type line_q;
      if (reset) begin
         foreach (walkable_cells[z, x])
            walkable_cells[z][x] = 1'b0;
         clear_expected.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (clear_expected.size() == 0) begin
               note_failure($sformatf("response transfer with no query pending, line_clear=%0b",
                                      rsp_line_clear));
            end else begin
               want = clear_expected.pop_front();
               if (rsp_line_clear !== want.clear)
                  note_failure($sformatf(
                     "line (%0d,%0d)->(%0d,%0d): line_clear expected %0b, got %0b",
                     want.x0, want.z0, want.x1, want.z1, want.clear, rsp_line_clear));
            end
         end
         if (req_valid && req_ready) begin
            if (req_cmd == glosc_pkg::CMD_WRITE) begin
               if (req_start_x < MAP_W && req_start_z < MAP_H)
                  walkable_cells[req_start_z][req_start_x] = req_cell_walkable;
            end else begin
               line_q.x0    = int'(req_start_x);
               line_q.z0    = int'(req_start_z);
               line_q.x1    = int'(req_end_x);
               line_q.z1    = int'(req_end_z);
               line_q.clear = walk_is_clear(line_q.x0, line_q.z0, line_q.x1, line_q.z1);
               clear_expected.insert(clear_expected.size(), line_q);
            end
         end
      end
      outstanding <= clear_expected.size();
   end

endmodule

// ===== dv/testbench.sv =====
// Stimulus and verdict for the grid line-of-sight checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW             = glosc_pkg::COORD_W;
   localparam int RANDOM_ITEMS   = 800;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int TAIL_CYCLES    = 80;
   localparam int MAX_C          = (1 << CW) - 1;

   typedef enum logic [1:0] {
      RDY_ALWAYS,
      RDY_HALF,
      RDY_SPARSE,
      RDY_LONG_STALL
   } ready_mode_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic          req_cmd = glosc_pkg::CMD_WRITE;
   logic [CW-1:0] req_start_x = '0;
   logic [CW-1:0] req_start_z = '0;
   logic [CW-1:0] req_end_x = '0;
   logic [CW-1:0] req_end_z = '0;
   logic          req_cell_walkable = 1'b0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic          rsp_line_clear;

   int fail_count;
   int outstanding;
   int burst_left = 0;
   int sent_count = 0;
   int quiet_cycles = 0;

   ready_mode_type ready_mode = RDY_ALWAYS;
   int             mode_left = 0;
   int             stall_left = 0;

   always #6 clock = ~clock;

   grid_line_of_sight_check DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_start_x       (req_start_x),
      .req_start_z       (req_start_z),
      .req_end_x         (req_end_x),
      .req_end_z         (req_end_z),
      .req_cell_walkable (req_cell_walkable),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_line_clear    (rsp_line_clear)
   );

   glosc_line_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_start_x       (req_start_x),
      .req_start_z       (req_start_z),
      .req_end_x         (req_end_x),
      .req_end_z         (req_end_z),
      .req_cell_walkable (req_cell_walkable),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_line_clear    (rsp_line_clear),
      .fail_count        (fail_count),
      .outstanding       (outstanding)
   );

   // Receiver: ready pattern switches mode every so often
   always @(posedge clock) begin
      if (mode_left == 0) begin
         mode_left  <= $urandom_range(16, 200);
         ready_mode <= ready_mode_type'($urandom_range(0, 3));
      end else begin
         mode_left <= mode_left - 1;
      end
      case (ready_mode)
         RDY_ALWAYS: begin
            rsp_ready <= 1'b1;
         end
         RDY_HALF: begin
            rsp_ready <= 1'($urandom_range(0, 1));
         end
         RDY_SPARSE: begin
            rsp_ready <= ($urandom_range(0, 4) == 0);
         end
         default: begin
            if (stall_left == 0) begin
               rsp_ready  <= 1'b1;
               stall_left <= $urandom_range(1, 40);
            end else begin
               rsp_ready  <= 1'b0;
               stall_left <= stall_left - 1;
            end
         end
      endcase
   end

   // Watchdog: too long without any transfer on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // One request transfer; bursts of random length with random gaps between
   task automatic send_req(logic cmd, int sx, int sz, int ex, int ez, logic walkable);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid         <= 1'b1;
      req_cmd           <= cmd;
      req_start_x       <= CW'(sx);
      req_start_z       <= CW'(sz);
      req_end_x         <= CW'(ex);
      req_end_z         <= CW'(ez);
      req_cell_walkable <= walkable;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   // End fields of a write are don't-care, so they carry noise
   task automatic write_cell(int x, int z, logic walkable);
      send_req(glosc_pkg::CMD_WRITE, x, z, $urandom_range(0, MAX_C), $urandom_range(0, MAX_C),
               walkable);
   endtask

   task automatic query_line(int x0, int z0, int x1, int z1);
      send_req(glosc_pkg::CMD_QUERY, x0, z0, x1, z1, 1'($urandom_range(0, 1)));
   endtask

   // Hold off the sender until every expected response has come back
   task automatic drain_pause();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic int clip(int v);
      return (v < 0) ? 0 : (v > MAX_C) ? MAX_C : v;
   endfunction

   initial begin
      int random_target;
      int r, wx, wz, n, len, ddx, ddz, sx, sz, blocked_at;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty map, corners, single-cell lines, a short corridor
      query_line(0, 0, MAX_C, MAX_C);
      query_line(5, 5, 5, 5);
      write_cell(0, 0, 1'b1);
      write_cell(MAX_C, MAX_C, 1'b1);
      send_req(glosc_pkg::CMD_WRITE, MAX_C, 0, MAX_C, MAX_C, 1'b1);
      write_cell(0, MAX_C, 1'b1);
      query_line(0, 0, 0, 0);
      query_line(MAX_C, MAX_C, MAX_C, MAX_C);
      query_line(0, 0, MAX_C, MAX_C);
      query_line(MAX_C, 0, 0, MAX_C);
      query_line(1, 1, 0, 0);
      for (int x = 20; x <= 23; x++)
         write_cell(x, 40, 1'b1);
      query_line(20, 40, 23, 40);
      query_line(23, 40, 20, 40);
      send_req(glosc_pkg::CMD_WRITE, 22, 40, 0, 0, 1'b0);
      query_line(20, 40, 23, 40);
      query_line(22, 40, 22, 40);
      write_cell(0, 0, 1'b0);
      query_line(0, 0, 0, 0);
      drain_pause();

      // Random part
      random_target = sent_count + RANDOM_ITEMS;
      while (sent_count < random_target) begin
         r = $urandom_range(0, 19);
         if (r < 10) begin
            // small window: mostly walkable writes, then queries starting inside it
            wx = $urandom_range(0, MAX_C - 5);
            wz = $urandom_range(0, MAX_C - 5);
            n  = $urandom_range(4, 12);
            repeat (n)
               write_cell(wx + $urandom_range(0, 5), wz + $urandom_range(0, 5),
                          $urandom_range(0, 9) != 0);
            n = $urandom_range(2, 5);
            repeat (n) begin
               if ($urandom_range(0, 3) == 0)
                  query_line(wx + $urandom_range(0, 5), wz + $urandom_range(0, 5),
                             clip(wx + $urandom_range(0, 16) - 8),
                             clip(wz + $urandom_range(0, 16) - 8));
               else
                  query_line(wx + $urandom_range(0, 5), wz + $urandom_range(0, 5),
                             wx + $urandom_range(0, 5), wz + $urandom_range(0, 5));
            end
         end else if (r < 15) begin
            // straight or 45-degree corridor, sometimes full length, sometimes cut
            len = ($urandom_range(0, 7) == 0) ? MAX_C + 1 : $urandom_range(1, 12);
            case ($urandom_range(0, 3))
               0:       begin ddx = 1; ddz = 0;  end
               1:       begin ddx = 0; ddz = 1;  end
               2:       begin ddx = 1; ddz = 1;  end
               default: begin ddx = 1; ddz = -1; end
            endcase
            sx = (ddx == 0) ? $urandom_range(0, MAX_C) : $urandom_range(0, MAX_C + 1 - len);
            if (ddz == 0)
               sz = $urandom_range(0, MAX_C);
            else if (ddz > 0)
               sz = $urandom_range(0, MAX_C + 1 - len);
            else
               sz = $urandom_range(len - 1, MAX_C);
            blocked_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : -1;
            for (int i = 0; i < len; i++)
               write_cell(sx + i * ddx, sz + i * ddz, i != blocked_at);
            query_line(sx, sz, sx + (len - 1) * ddx, sz + (len - 1) * ddz);
            query_line(sx + (len - 1) * ddx, sz + (len - 1) * ddz, sx, sz);
         end else if (r < 17) begin
            // noise: fully random items
            n = $urandom_range(1, 6);
            repeat (n)
               send_req(1'($urandom_range(0, 1)), $urandom_range(0, MAX_C),
                        $urandom_range(0, MAX_C), $urandom_range(0, MAX_C),
                        $urandom_range(0, MAX_C), 1'($urandom_range(0, 1)));
         end else if (r < 19) begin
            query_line($urandom_range(0, MAX_C), $urandom_range(0, MAX_C),
                       $urandom_range(0, MAX_C), $urandom_range(0, MAX_C));
         end else begin
            drain_pause();
         end
      end

      // Let everything drain, then a tail for any stray response
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0 && outstanding == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== grid_line_of_sight_check.f =====
+incdir+rtl
rtl/glosc_pkg.sv
rtl/glosc_map.sv
rtl/glosc_step.sv
rtl/grid_line_of_sight_check.sv
dv/glosc_line_checker.sv
dv/testbench.sv
